@@ rtl/core/bracket_balance_checker_macros.svh @@
// ----------------------------------------------------------------------------
// Bracket balance checker assertion macros
// Clocked assertion shorthands shared by the checker RTL; ASSERT_OFF drops them.
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF

// plain property, checked out of reset
`define BBC_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// same-cycle implication
`define BBC_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BBC_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define BBC_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg)
`define BBC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

@@ rtl/core/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Widths, character and error codes, and the op type passed front to back.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam int BYTE_W  = 8;
    localparam int DEPTH_W = 7;
    localparam int ERR_W   = 3;
    localparam int KIND_W  = 2;
    localparam int OP_W    = 2;

    // op queue, power of two deep
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;

    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAREN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BRACE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd3;

    localparam logic [OP_W-1:0] OP_NONE = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH = 2'd1;
    localparam logic [OP_W-1:0] OP_POP  = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_MISMATCH = 3'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd3;
    localparam logic [ERR_W-1:0] ERR_UNCLOSED = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KIND_W-1:0] kind;
        logic              last;
    } bbc_op_t;

    // queue side status seen by the back end
    typedef struct packed {
        logic    valid;
        bbc_op_t head;
    } bbc_head_t;

endpackage

@@ rtl/core/bbc_ifs.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker channels
// Valid/ready interfaces for text beats in and result beats out.
// ----------------------------------------------------------------------------
interface bbc_text_if;
    import bbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface bbc_result_if;
    import bbc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] nest_depth;
    logic [ERR_W-1:0]   error_code;
    logic               balanced;
    logic               text_done;

    modport source (output valid, output nest_depth, output error_code,
                    output balanced, output text_done, input ready);
    modport sink   (input valid, input nest_depth, input error_code,
                    input balanced, input text_done, output ready);
endinterface

@@ rtl/core/bbc_front.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker front end
// Accepts text beats and decodes each byte into a push, pop or no-op.
// ----------------------------------------------------------------------------
module bbc_front (
    bbc_text_if.sink         text,
    input  logic             q_full,
    output logic             q_push,
    output bbc_pkg::bbc_op_t q_op
);
    import bbc_pkg::*;

    assign text.ready = !q_full;
    assign q_push     = text.valid && !q_full;

    always_comb
    begin
        q_op.op   = OP_NONE;
        q_op.kind = KIND_NONE;
        q_op.last = text.end_of_text;
        case (text.text_byte)
            CH_LPAREN: begin q_op.op = OP_PUSH; q_op.kind = KIND_PAREN;  end
            CH_LBRACE: begin q_op.op = OP_PUSH; q_op.kind = KIND_BRACE;  end
            CH_LBRACK: begin q_op.op = OP_PUSH; q_op.kind = KIND_SQUARE; end
            CH_RPAREN: begin q_op.op = OP_POP;  q_op.kind = KIND_PAREN;  end
            CH_RBRACE: begin q_op.op = OP_POP;  q_op.kind = KIND_BRACE;  end
            CH_RBRACK: begin q_op.op = OP_POP;  q_op.kind = KIND_SQUARE; end
            default:   ;
        endcase
    end

endmodule

@@ rtl/core/bbc_op_queue.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker op queue
// Small FIFO of decoded ops between front and back; push and pop same cycle.
// ----------------------------------------------------------------------------
`include "bracket_balance_checker_macros.svh"

module bbc_op_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bbc_pkg::bbc_op_t   push_op,
    input  logic               pop,
    output logic               full,
    output bbc_pkg::bbc_head_t head
);
    import bbc_pkg::*;

    bbc_op_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    `BBC_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= QCNT_W'(QUEUE_DEPTH), "queue count over depth")
    `BBC_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, cnt_reg != '0, "pop from empty queue")
    `BBC_ASSERT(a_ptr_sync, clk, rst_n, (wr_ptr_reg - rd_ptr_reg) == cnt_reg[QPTR_W-1:0], "queue pointers out of step with count")

endmodule

@@ rtl/core/bbc_back.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker back end
// Bracket stack engine: one push or pop per beat, registered result beat.
// ----------------------------------------------------------------------------
`include "bracket_balance_checker_macros.svh"

module bbc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  bbc_pkg::bbc_head_t head,
    output logic               pop,
    bbc_result_if.source       result
);
    import bbc_pkg::*;

    // stack storage; top entry is also mirrored in top_reg, and below_q
    // holds the entry under it (registered read at sp-2 every cycle)
    logic [KIND_W-1:0]  stack_mem [STACK_DEPTH];
    logic [KIND_W-1:0]  below_q;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;

    logic [SP_W-1:0]    sp_reg, sp_next, sp_new;
    logic [ERR_W-1:0]   err_reg, err_next, err_new;
    logic [KIND_W-1:0]  top_reg, top_next, top_new;
    logic               push_ok;

    logic               out_valid_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [ERR_W-1:0]   code_reg;
    logic               bal_reg;
    logic               done_reg;
    logic               fire;

    assign fire = head.valid && (!out_valid_reg || result.ready);
    assign pop  = fire;

    always_comb
    begin
        sp_new  = sp_reg;
        err_new = err_reg;
        top_new = top_reg;
        push_ok = 1'b0;
        if (err_reg == ERR_NONE)
        begin
            case (head.head.op)
                OP_PUSH:
                begin
                    if (sp_reg == SP_W'(STACK_DEPTH))
                    begin
                        err_new = ERR_OVERFLOW;
                    end
                    else
                    begin
                        push_ok = 1'b1;
                        sp_new  = sp_reg + SP_W'(1);
                        top_new = head.head.kind;
                    end
                end
                OP_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        err_new = ERR_EMPTY;
                    end
                    else
                    begin
                        sp_new  = sp_reg - SP_W'(1);
                        top_new = below_q;
                        if (top_reg != head.head.kind)
                        begin
                            err_new = ERR_MISMATCH;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (head.head.last && (err_new == ERR_NONE) && (sp_new != '0))
        begin
            err_new = ERR_UNCLOSED;
        end
    end

    always_comb
    begin
        sp_next  = sp_reg;
        err_next = err_reg;
        top_next = top_reg;
        if (fire)
        begin
            sp_next  = head.head.last ? '0 : sp_new;
            err_next = head.head.last ? ERR_NONE : err_new;
            top_next = top_new;
        end
    end

    assign wr_en   = fire && push_ok;
    assign rd_addr = ADDR_W'(sp_next - SP_W'(2));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[sp_reg[ADDR_W-1:0]] <= head.head.kind;
        end
        below_q <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg  <= sp_next;
            err_reg <= err_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (fire)
        begin
            depth_reg <= DEPTH_W'(sp_new);
            code_reg  <= err_new;
            bal_reg   <= head.head.last && (err_new == ERR_NONE);
            done_reg  <= head.head.last;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.nest_depth = depth_reg;
    assign result.error_code = code_reg;
    assign result.balanced   = bal_reg;
    assign result.text_done  = done_reg;

    `BBC_ASSERT(a_sp_bound, clk, rst_n, sp_reg <= SP_W'(STACK_DEPTH), "stack pointer past depth")
    `BBC_ASSERT_NEXT(a_eot_clear, clk, rst_n, fire && head.head.last, (sp_reg == '0) && (err_reg == ERR_NONE), "state not cleared after end of text")
    `BBC_ASSERT_NEXT(a_err_freeze, clk, rst_n, (err_reg != ERR_NONE) && !(fire && head.head.last), $stable(sp_reg) && $stable(err_reg), "stack moved after sticky error")
    `BBC_ASSERT_IMPL(a_bal_clean, clk, rst_n, out_valid_reg && bal_reg, done_reg && (code_reg == ERR_NONE), "balanced flag on bad result")

endmodule

@@ rtl/core/bracket_balance_checker.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker
// Streaming check of (), {} and [] nesting, one text byte per beat.
// ----------------------------------------------------------------------------
// Sustains one text beat per clock while the output is not stalled, and
// gives one result beat per text beat. A beat is written into the op queue
// when accepted and does its stack step when it leaves the queue, which also
// loads the result register. The rate is set by the stack engine, which
// does one push or pop per cycle while the output is not stalled: the top
// entry sits in a register and the entry under it is prefetched from the
// stack memory every cycle, so back-to-back pops and pushes need no stall.
// A two-entry op queue lets the input keep flowing while a result beat
// waits on the output; while the output stalls with a result beat waiting,
// two more text beats are taken into the queue and the input then stalls
// until the queue has room again. The stack memory needs no clearing after
// reset: only entries below the stack pointer are ever used.
// Errors are sticky per text; the result for the final byte (end_of_text)
// carries the unclosed check and the balanced flag, after which depth and
// error start over at zero for the next text.
// ----------------------------------------------------------------------------
module bracket_balance_checker (
    input  logic         clk,
    input  logic         rst_n,
    bbc_text_if.sink     text,
    bbc_result_if.source result
);
    import bbc_pkg::*;

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    bbc_op_t   q_op;
    bbc_head_t q_head;

    // decode: byte -> push/pop/no-op plus kind
    bbc_front u_front (
        .text   (text),
        .q_full (q_full),
        .q_push (q_push),
        .q_op   (q_op)
    );

    // decouples decode from the stack engine
    bbc_op_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_op),
        .pop     (q_pop),
        .full    (q_full),
        .head    (q_head)
    );

    // stack engine and result register
    bbc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .pop    (q_pop),
        .result (result)
    );

endmodule
